@@ sv/ost_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the octahedron sphere tessellator.
// No dependencies; the tessellator and its bench import this package.
package ost_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_DIV_INIT,
        ST_DIV,
        ST_STEP,
        ST_POS,
        ST_HSQ,
        ST_HROOT,
        ST_CORDIC,
        ST_FIN
    } state_t;

    typedef logic signed [15:0] comp_t;

    // configuration register indexes
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_DETAIL = 1'b1;

    localparam logic [15:0] RADIUS_RESET = 16'd256;
    localparam logic [1:0]  DETAIL_RESET = 2'd3;

    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // last count of each iterative pass
    localparam logic [4:0] ROOT_LAST   = 5'd23;
    localparam logic [4:0] DIV_LAST    = 5'd14;
    localparam logic [4:0] CORDIC_LAST = 5'd15;

    // corner axes of the eight faces
    localparam logic [2:0] FACE_TAB [8][3] = '{
        '{3'd4, 3'd3, 3'd0}, '{3'd1, 3'd4, 3'd0}, '{3'd3, 3'd4, 3'd5}, '{3'd4, 3'd1, 3'd5},
        '{3'd0, 3'd3, 3'd2}, '{3'd0, 3'd2, 3'd1}, '{3'd5, 3'd2, 3'd3}, '{3'd5, 3'd1, 3'd2}
    };

    // unit axes as -1, 0, +1
    localparam logic signed [1:0] AXIS_TAB [6][3] = '{
        '{2'b00, 2'b00, 2'b11}, '{2'b01, 2'b00, 2'b00}, '{2'b00, 2'b11, 2'b00},
        '{2'b11, 2'b00, 2'b00}, '{2'b00, 2'b01, 2'b00}, '{2'b00, 2'b00, 2'b01}
    };

    // arctangent of 2^-i, half turn = 65536
    localparam logic [14:0] ATAN_TAB [16] = '{
        15'd16384, 15'd9672, 15'd5110, 15'd2594, 15'd1302, 15'd652, 15'd326, 15'd163,
        15'd81, 15'd41, 15'd20, 15'd10, 15'd5, 15'd3, 15'd1, 15'd1
    };

endpackage

@@ sv/ost_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the tessellator: triangle index and corner.
// Depends on nothing.
interface ost_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] triangle_index;
    logic [1:0] corner;

    modport source (output valid, output triangle_index, output corner, input ready);
    modport sink (input valid, input triangle_index, input corner, output ready);
endinterface

@@ sv/ost_out_if.sv @@
`timescale 1ns / 1ps
// Output channel of the tessellator: position, normal, texture coordinates.
// Depends on nothing.
interface ost_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [0:0]         tex_u;
    logic [16:0]        tex_v;
    logic               in_range;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output norm_x, output norm_y, output norm_z, output tex_u,
                    output tex_v, output in_range, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input norm_x, input norm_y, input norm_z, input tex_u,
                  input tex_v, input in_range, output ready);
endinterface

@@ sv/octahedron_sphere_tessellator.sv @@
`timescale 1ns / 1ps
// Octahedron sphere tessellator: one vertex of a subdivided octahedron per word.
// Depends on ost_pkg, ost_in_if and ost_out_if.

// One word at a time: the block takes a word only when idle and returns one result for it
// after the full sequence for the applied detail level, or straight from the final state
// for an index out of range. The work runs on one shared 17x17 multiplier, a bit-serial
// square root, a restoring divider run once per component and a 16-step CORDIC, all run
// in turn by the sequencer. A finished result sits in an output register, so the next
// word may be accepted while it waits.
module octahedron_sphere_tessellator
    import ost_pkg::*;
#(
    parameter int MAX_DETAIL = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    ost_in_if.sink      in_ch,
    ost_out_if.source   out_ch
);

    state_t state_reg, state_next;

    logic [15:0] radius_reg, radius_next;
    logic [1:0]  detail_reg, detail_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  lvl_reg, lvl_next;
    logic [1:0]  m_reg, m_next;
    logic [1:0]  j_reg, j_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [8:0]  idx_reg, idx_next;
    logic [1:0]  corner_reg, corner_next;
    logic [1:0]  d_reg, d_next;
    logic        rng_reg, rng_next;
    comp_t       tri_reg [3][3];
    comp_t       tri_next [3][3];
    comp_t       mid_reg [3][3];
    comp_t       mid_next [3][3];
    logic [31:0] acc_reg, acc_next;
    logic [47:0] rad_reg, rad_next;
    logic [25:0] srem_reg, srem_next;
    logic [23:0] root_reg, root_next;
    logic [23:0] drem_reg, drem_next;
    logic [14:0] nlow_reg, nlow_next;
    logic [14:0] q_reg, q_next;
    logic signed [25:0] xx_reg, xx_next;
    logic signed [25:0] yy_reg, yy_next;
    logic signed [17:0] ang_reg, ang_next;
    logic signed [16:0] pos_reg [3];
    logic signed [16:0] pos_next [3];

    logic signed [16:0] opos_reg [3];
    logic signed [16:0] opos_next [3];
    comp_t       onorm_reg [3];
    comp_t       onorm_next [3];
    logic [16:0] otexv_reg, otexv_next;
    logic        orng_reg, orng_next;

    // input decode
    logic [1:0]  d_in;
    logic [8:0]  face_full;
    logic        in_rng;
    logic [2:0]  face_in;

    // midpoint operands
    logic [1:0]  pa, pb;
    comp_t       p_j, q_j;
    logic signed [16:0] v_j;
    logic [15:0] vmag;
    logic        vneg;

    // picked vertex
    comp_t       pick [3];
    comp_t       pick_j;
    logic [15:0] pmag_j;
    logic [15:0] pmag_y;

    // shared multiplier
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod;
    logic [31:0] acc_sum;
    logic [33:0] pround;
    logic signed [16:0] pval;

    // square root step
    logic [27:0] sq_rem2, sq_trial;
    logic        sq_ge;
    logic [23:0] root_step;
    logic [25:0] srem_step;

    // divider step
    logic [38:0] nfull;
    logic [24:0] dv_rem2;
    logic        dv_ge;
    logic [14:0] qf, qc;
    comp_t       midval;

    // CORDIC step
    logic [3:0]  ci;
    logic signed [25:0] sx, sy;
    logic signed [17:0] atan_v;
    logic signed [17:0] ang_c;
    logic [16:0] texv;

    // level step
    logic [1:0]  sh2;
    logic [1:0]  dig;
    logic        out_load;

    function automatic logic signed [25:0] sra_tz(input logic signed [25:0] v,
                                                  input logic [3:0] sh);
        logic [25:0] mag;
        logic [25:0] r;
        mag = v[25] ? 26'(-v) : 26'(v);
        r   = mag >> sh;
        return v[25] ? -signed'(r) : signed'(r);
    endfunction

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        d_in      = (int'(detail_reg) > MAX_DETAIL) ? 2'(MAX_DETAIL) : detail_reg;
        face_full = in_ch.triangle_index >> {d_in, 1'b0};
        in_rng    = face_full < 9'd8;
        face_in   = face_full[2:0];

        pa   = (m_reg == 2'd2) ? 2'd1 : 2'd0;
        pb   = (m_reg == 2'd0) ? 2'd1 : 2'd2;
        p_j  = tri_reg[pa][j_reg];
        q_j  = tri_reg[pb][j_reg];
        v_j  = 17'(p_j) + 17'(q_j);
        vneg = v_j[16];
        vmag = vneg ? 16'(-v_j) : 16'(v_j);

        for (int k = 0; k < 3; k++)
        begin
            pick[k] = tri_reg[corner_reg][k];
        end
        pick_j = pick[j_reg];
        pmag_j = pick_j[15] ? 16'(-pick_j) : 16'(pick_j);
        pmag_y = pick[1][15] ? 16'(-pick[1]) : 16'(pick[1]);

        sh2 = d_reg - 2'd1 - lvl_reg;
        dig = 2'(idx_reg >> {sh2, 1'b0});
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_SQ:
            begin
                mul_a = v_j;
                mul_b = v_j;
            end
            ST_POS:
            begin
                mul_a = signed'({1'b0, pmag_j});
                mul_b = signed'({1'b0, radius_reg});
            end
            ST_HSQ:
            begin
                mul_a = 17'((j_reg == 2'd0) ? pick[0] : pick[2]);
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod    = mul_a * mul_b;
        acc_sum = acc_reg + prod[31:0];
        pround  = 34'(prod) + 34'd8192;
        pval    = signed'(pround[30:14]);
    end

    // square root, divider and CORDIC steps
    always_comb
    begin
        sq_rem2   = {srem_reg, rad_reg[47:46]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_ge     = sq_rem2 >= sq_trial;
        root_step = {root_reg[22:0], sq_ge};
        srem_step = sq_ge ? 26'(sq_rem2 - sq_trial) : sq_rem2[25:0];

        nfull   = 39'({vmag, 22'b0}) + 39'(root_reg[23:1]);
        dv_rem2 = {drem_reg, nlow_reg[14]};
        dv_ge   = dv_rem2 >= {1'b0, root_reg};
        qf      = {q_reg[13:0], dv_ge};
        qc      = (qf > ONE_Q14) ? ONE_Q14 : qf;
        if (root_reg == '0)
        begin
            midval = p_j;
        end
        else
        begin
            midval = vneg ? -signed'({1'b0, qc}) : signed'({1'b0, qc});
        end

        ci     = cnt_reg[3:0];
        sx     = sra_tz(xx_reg, ci);
        sy     = sra_tz(yy_reg, ci);
        atan_v = signed'({3'b000, ATAN_TAB[ci]});

        if (root_reg == '0)
        begin
            ang_c = '0;
        end
        else if (pick[1] == '0)
        begin
            ang_c = 18'sd32768;
        end
        else if (ang_reg < 0)
        begin
            ang_c = '0;
        end
        else if (ang_reg > 18'sd32768)
        begin
            ang_c = 18'sd32768;
        end
        else
        begin
            ang_c = ang_reg;
        end
        texv = pick[1][15] ? 17'(ang_c) : 17'(18'sd65536 - ang_c);
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (!in_rng)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (d_in == 2'd0)
                    begin
                        state_next = ST_POS;
                    end
                    else
                    begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ:
            begin
                if (j_reg == 2'd2)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    if (j_reg != 2'd2)
                    begin
                        state_next = ST_DIV_INIT;
                    end
                    else if (m_reg != 2'd2)
                    begin
                        state_next = ST_SQ;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                state_next = (lvl_reg == d_reg - 2'd1) ? ST_POS : ST_SQ;
            end
            ST_POS:
            begin
                if (j_reg == 2'd2)
                begin
                    state_next = ST_HSQ;
                end
            end
            ST_HSQ:
            begin
                if (j_reg == 2'd1)
                begin
                    state_next = ST_HROOT;
                end
            end
            ST_HROOT:
            begin
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        radius_next    = radius_reg;
        detail_next    = detail_reg;
        out_valid_next = out_valid_reg;
        lvl_next       = lvl_reg;
        m_next         = m_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        corner_next    = corner_reg;
        d_next         = d_reg;
        rng_next       = rng_reg;
        tri_next       = tri_reg;
        mid_next       = mid_reg;
        acc_next       = acc_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        nlow_next      = nlow_reg;
        q_next         = q_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        ang_next       = ang_reg;
        pos_next       = pos_reg;
        opos_next      = opos_reg;
        onorm_next     = onorm_reg;
        otexv_next     = otexv_reg;
        orng_next      = orng_reg;
        out_load       = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_next = cfg_data;
                REG_DETAIL: detail_next = cfg_data[1:0];
                default:    radius_next = radius_reg;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    idx_next    = in_ch.triangle_index;
                    corner_next = (in_ch.corner == 2'd3) ? 2'd2 : in_ch.corner;
                    d_next      = d_in;
                    rng_next    = in_rng;
                    lvl_next    = '0;
                    m_next      = '0;
                    j_next      = '0;
                    cnt_next    = '0;
                    acc_next    = '0;
                    for (int c = 0; c < 3; c++)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            tri_next[c][k] = 16'(AXIS_TAB[FACE_TAB[face_in][c]][k]) <<< 14;
                        end
                    end
                end
            end
            ST_SQ:
            begin
                acc_next = acc_sum;
                j_next   = j_reg + 2'd1;
                if (j_reg == 2'd2)
                begin
                    j_next    = '0;
                    rad_next  = {acc_sum, 16'b0};
                    srem_next = '0;
                    root_next = '0;
                    cnt_next  = '0;
                end
            end
            ST_ROOT, ST_HROOT:
            begin
                rad_next  = rad_reg << 2;
                srem_next = srem_step;
                root_next = root_step;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == ROOT_LAST)
                begin
                    cnt_next = '0;
                    if (state_reg == ST_HROOT)
                    begin
                        xx_next  = signed'(26'(pmag_y) << 8);
                        yy_next  = signed'(26'(root_step));
                        ang_next = '0;
                    end
                end
            end
            ST_DIV_INIT:
            begin
                drem_next = nfull[38:15];
                nlow_next = nfull[14:0];
                q_next    = '0;
                cnt_next  = '0;
            end
            ST_DIV:
            begin
                drem_next = dv_ge ? 24'(dv_rem2 - {1'b0, root_reg}) : dv_rem2[23:0];
                nlow_next = nlow_reg << 1;
                q_next    = qf;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    mid_next[m_reg][j_reg] = midval;
                    cnt_next = '0;
                    if (j_reg != 2'd2)
                    begin
                        j_next = j_reg + 2'd1;
                    end
                    else
                    begin
                        j_next = '0;
                        if (m_reg != 2'd2)
                        begin
                            m_next   = m_reg + 2'd1;
                            acc_next = '0;
                        end
                    end
                end
            end
            ST_STEP:
            begin
                // mid 0 = ab, mid 1 = ac, mid 2 = bc
                case (dig)
                    2'd0:
                    begin
                        tri_next[0] = tri_reg[0];
                        tri_next[1] = mid_reg[0];
                        tri_next[2] = mid_reg[1];
                    end
                    2'd1:
                    begin
                        tri_next[0] = tri_reg[1];
                        tri_next[1] = mid_reg[2];
                        tri_next[2] = mid_reg[0];
                    end
                    2'd2:
                    begin
                        tri_next[0] = tri_reg[2];
                        tri_next[1] = mid_reg[1];
                        tri_next[2] = mid_reg[2];
                    end
                    default:
                    begin
                        tri_next[0] = mid_reg[0];
                        tri_next[1] = mid_reg[2];
                        tri_next[2] = mid_reg[1];
                    end
                endcase
                lvl_next = lvl_reg + 2'd1;
                m_next   = '0;
                j_next   = '0;
                acc_next = '0;
            end
            ST_POS:
            begin
                pos_next[j_reg] = pick_j[15] ? -pval : pval;
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd2)
                begin
                    j_next   = '0;
                    acc_next = '0;
                end
            end
            ST_HSQ:
            begin
                acc_next = acc_sum;
                j_next   = j_reg + 2'd1;
                if (j_reg == 2'd1)
                begin
                    j_next    = '0;
                    rad_next  = {acc_sum, 16'b0};
                    srem_next = '0;
                    root_next = '0;
                    cnt_next  = '0;
                end
            end
            ST_CORDIC:
            begin
                // stop rotating once the y residual is exactly zero
                if (yy_reg > 0)
                begin
                    xx_next  = xx_reg + sy;
                    yy_next  = yy_reg - sx;
                    ang_next = ang_reg + atan_v;
                end
                else if (yy_reg < 0)
                begin
                    xx_next  = xx_reg - sy;
                    yy_next  = yy_reg + sx;
                    ang_next = ang_reg - atan_v;
                end
                cnt_next = (cnt_reg == CORDIC_LAST) ? 5'd0 : cnt_reg + 5'd1;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    orng_next      = rng_reg;
                    for (int k = 0; k < 3; k++)
                    begin
                        opos_next[k]  = rng_reg ? pos_reg[k] : '0;
                        onorm_next[k] = rng_reg ? pick[k] : '0;
                    end
                    otexv_next = rng_reg ? texv : '0;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= RADIUS_RESET;
            detail_reg    <= DETAIL_RESET;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            m_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            detail_reg    <= detail_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
            m_reg         <= m_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        corner_reg <= corner_next;
        d_reg      <= d_next;
        rng_reg    <= rng_next;
        tri_reg    <= tri_next;
        mid_reg    <= mid_next;
        acc_reg    <= acc_next;
        rad_reg    <= rad_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        nlow_reg   <= nlow_next;
        q_reg      <= q_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        ang_reg    <= ang_next;
        pos_reg    <= pos_next;
        opos_reg   <= opos_next;
        onorm_reg  <= onorm_next;
        otexv_reg  <= otexv_next;
        orng_reg   <= orng_next;
    end

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.pos_x    = opos_reg[0];
    assign out_ch.pos_y    = opos_reg[1];
    assign out_ch.pos_z    = opos_reg[2];
    assign out_ch.norm_x   = onorm_reg[0];
    assign out_ch.norm_y   = onorm_reg[1];
    assign out_ch.norm_z   = onorm_reg[2];
    assign out_ch.tex_u    = 1'b0;
    assign out_ch.tex_v    = otexv_reg;
    assign out_ch.in_range = orng_reg;

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> state_reg != ST_IDLE)
        else $error("accepted word did not start the sequencer");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_ch.valid)
        else $error("result load did not raise valid");

    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.norm_x <= 16'sd16384 && out_ch.norm_x >= -16'sd16384
                          && out_ch.norm_y <= 16'sd16384 && out_ch.norm_y >= -16'sd16384))
        else $error("normal component out of unit range");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.in_range |-> out_ch.tex_v == '0 && out_ch.pos_x == '0)
        else $error("out-of-range result carries data");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= DIV_LAST)
        else $error("divider ran past its last step");
`endif

endmodule

@@ sim/octahedron_sphere_tessellator_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for octahedron_sphere_tessellator: a directed table, then random
// triangle/corner words over several radius and detail settings, checked by a predictor.
// Depends on ost_pkg, ost_in_if, ost_out_if and the block itself.
module octahedron_sphere_tessellator_test;
    import ost_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int TAIL_CYCLES  = 800;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic        tex_u;
        logic [16:0] tex_v;
        logic        in_range;
    } vertex_t;

    typedef struct {
        logic [15:0] radius;
        logic [1:0]  detail;
        logic [8:0]  tri_idx;
        logic [1:0]  corner;
        bit          typed;
        vertex_t     want;
    } row_t;

    // face corners as axis numbers, axes as signed unit steps
    localparam int FACE_CORNERS [8][3] = '{
        '{4, 3, 0}, '{1, 4, 0}, '{3, 4, 5}, '{4, 1, 5},
        '{0, 3, 2}, '{0, 2, 1}, '{5, 2, 3}, '{5, 1, 2}
    };
    localparam int AXIS_DIR [6][3] = '{
        '{0, 0, -1}, '{1, 0, 0}, '{0, -1, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}
    };
    localparam int ATAN_STEP [16] = '{
        16384, 9672, 5110, 2594, 1302, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    ost_in_if  in_ch ();
    ost_out_if out_ch ();

    octahedron_sphere_tessellator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    logic [15:0] radius_now;
    logic [1:0]  detail_now;
    vertex_t     vertex_q [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    bit          hold_done;
    int          hold_left;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint shr_sym(longint v, int sh);
        return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
    endfunction

    // normalized direction of p + q
    function automatic void unit_mid(input int p [3], input int q [3], output int o [3]);
        longint          v [3];
        longint unsigned s;
        longint unsigned len;
        longint unsigned mag;
        longint unsigned qv;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = longint'(p[i]) + longint'(q[i]);
            s += longint'(v[i] * v[i]);
        end
        len = isqrt(s << 16);
        if (len == 0) begin
            o = p;
            return;
        end
        for (int i = 0; i < 3; i++) begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            qv = ((mag << 22) + (len >> 1)) / len;
            if (qv > 16384) qv = 16384;
            o[i] = (v[i] < 0) ? -int'(qv) : int'(qv);
        end
    endfunction

    function automatic logic [16:0] latitude_v(int n [3]);
        longint yy;
        longint xx;
        longint ang;
        longint nx;
        longint ny;
        yy = longint'(isqrt(longint'(longint'(n[0]) * n[0] + longint'(n[2]) * n[2]) << 16));
        xx = longint'((n[1] < 0) ? -n[1] : n[1]) * 256;
        ang = 0;
        if (yy == 0) ang = 0;
        else if (xx == 0) ang = 32768;
        else begin
            for (int i = 0; i < 16; i++) begin
                if (yy == 0) break;
                if (yy > 0) begin
                    nx = xx + shr_sym(yy, i);
                    ny = yy - shr_sym(xx, i);
                    ang += ATAN_STEP[i];
                end
                else begin
                    nx = xx - shr_sym(yy, i);
                    ny = yy + shr_sym(xx, i);
                    ang -= ATAN_STEP[i];
                end
                xx = nx;
                yy = ny;
            end
            if (ang < 0) ang = 0;
            if (ang > 32768) ang = 32768;
        end
        if (n[1] < 0) ang = 65536 - ang;
        return 17'(65536 - ang);
    endfunction

    function automatic vertex_t sphere_vertex(logic [8:0] idx, logic [1:0] corner_in,
                                              logic [15:0] rad, logic [1:0] det);
        vertex_t r;
        int      d;
        int      c;
        int      face;
        int      dig;
        int      vtx [3][3];
        int      mid [3][3];
        int      nxt [3][3];
        int      pick [3];
        longint  mag;
        longint  p;
        r = '0;
        d = (det > 3) ? 3 : det;
        if (int'(idx) >= (8 << (2 * d))) return r;
        c = (corner_in > 2) ? 2 : corner_in;
        face = (idx >> (2 * d)) & 7;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                vtx[i][j] = AXIS_DIR[FACE_CORNERS[face][i]][j] * 16384;
        for (int lvl = 0; lvl < d; lvl++) begin
            dig = (idx >> (2 * (d - 1 - lvl))) & 3;
            unit_mid(vtx[0], vtx[1], mid[0]);
            unit_mid(vtx[0], vtx[2], mid[1]);
            unit_mid(vtx[1], vtx[2], mid[2]);
            case (dig)
                0: begin nxt[0] = vtx[0]; nxt[1] = mid[0]; nxt[2] = mid[1]; end
                1: begin nxt[0] = vtx[1]; nxt[1] = mid[2]; nxt[2] = mid[0]; end
                2: begin nxt[0] = vtx[2]; nxt[1] = mid[1]; nxt[2] = mid[2]; end
                default: begin nxt[0] = mid[0]; nxt[1] = mid[2]; nxt[2] = mid[1]; end
            endcase
            vtx = nxt;
        end
        pick = vtx[c];
        mag = (pick[0] < 0) ? -pick[0] : pick[0];
        p = (mag * rad + 8192) >>> 14;
        r.pos_x = 17'((pick[0] < 0) ? -p : p);
        mag = (pick[1] < 0) ? -pick[1] : pick[1];
        p = (mag * rad + 8192) >>> 14;
        r.pos_y = 17'((pick[1] < 0) ? -p : p);
        mag = (pick[2] < 0) ? -pick[2] : pick[2];
        p = (mag * rad + 8192) >>> 14;
        r.pos_z = 17'((pick[2] < 0) ? -p : p);
        r.norm_x = 16'(pick[0]);
        r.norm_y = 16'(pick[1]);
        r.norm_z = 16'(pick[2]);
        r.tex_u = 1'b0;
        r.tex_v = latitude_v(pick);
        r.in_range = 1'b1;
        return r;
    endfunction

    function automatic vertex_t mk_vertex(int px, int py, int pz, int nx, int ny, int nz,
                                          int tv, bit ok);
        vertex_t r;
        r.pos_x = 17'(px);
        r.pos_y = 17'(py);
        r.pos_z = 17'(pz);
        r.norm_x = 16'(nx);
        r.norm_y = 16'(ny);
        r.norm_z = 16'(nz);
        r.tex_u = 1'b0;
        r.tex_v = 17'(tv);
        r.in_range = ok;
        return r;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done) begin
            out_ch.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        vertex_t got;
        vertex_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.pos_x = out_ch.pos_x;
            got.pos_y = out_ch.pos_y;
            got.pos_z = out_ch.pos_z;
            got.norm_x = out_ch.norm_x;
            got.norm_y = out_ch.norm_y;
            got.norm_z = out_ch.norm_z;
            got.tex_u = out_ch.tex_u;
            got.tex_v = out_ch.tex_v;
            got.in_range = out_ch.in_range;
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end
            else begin
                want = vertex_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // drop valid, then wait until every expected word is back
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (vertex_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_data = 16'($urandom);
        if (idx == REG_RADIUS) radius_now = val;
        else detail_now = val[1:0];
    endtask

    task automatic set_config(logic [15:0] rad, logic [1:0] det);
        if (rad === radius_now && det === detail_now) return;
        wait_drained();
        write_reg(REG_RADIUS, rad);
        write_reg(REG_DETAIL, {14'($urandom), det});
    endtask

    task automatic send_word(logic [8:0] idx, logic [1:0] corner_in, bit typed, vertex_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.triangle_index = idx;
        in_ch.corner = corner_in;
        do @(posedge clk); while (!in_ch.ready);
        vertex_q.push_back(typed ? want
                                 : sphere_vertex(idx, corner_in, radius_now, detail_now));
    endtask

    row_t    rows [$];
    vertex_t none;

    task automatic add_row(int rad, int det, int idx, int c, bit typed, vertex_t want);
        row_t r;
        r.radius = 16'(rad);
        r.detail = 2'(det);
        r.tri_idx = 9'(idx);
        r.corner = 2'(c);
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    initial begin
        int          plan_det [4];
        int          plan_cnt [4];
        int          lim;
        logic [15:0] rad;
        logic [8:0]  idx;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.triangle_index = '0;
        in_ch.corner = '0;
        hold_req = 1'b0;
        radius_now = RADIUS_RESET;
        detail_now = DETAIL_RESET;
        send_idle_pct = 36;
        recv_idle_pct = 48;
        none = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // top pole straight after reset, then the rest of the table
        add_row(256, 3, 0, 0, 1, mk_vertex(0, 256, 0, 0, 16384, 0, 65536, 1));
        add_row(256, 3, 511, 3, 0, none);
        add_row(256, 3, 300, 2, 0, none);
        add_row(256, 3, 255, 1, 0, none);
        add_row(256, 0, 8, 0, 1, mk_vertex(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(256, 0, 511, 3, 1, mk_vertex(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(256, 0, 4, 2, 1, mk_vertex(0, -256, 0, 0, -16384, 0, 0, 1));
        add_row(256, 0, 7, 3, 0, none);
        add_row(65535, 0, 2, 0, 1, mk_vertex(-65535, 0, 0, -16384, 0, 0, 32768, 1));
        add_row(65535, 0, 6, 1, 0, none);
        add_row(0, 0, 5, 1, 1, mk_vertex(0, 0, 0, 0, -16384, 0, 0, 1));
        add_row(0, 1, 31, 1, 0, none);
        add_row(256, 1, 32, 0, 1, mk_vertex(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(256, 1, 0, 1, 0, none);
        add_row(256, 1, 13, 2, 0, none);
        add_row(256, 1, 22, 0, 0, none);
        add_row(256, 1, 31, 3, 0, none);
        add_row(300, 2, 127, 2, 0, none);
        add_row(300, 2, 128, 1, 1, mk_vertex(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(300, 2, 64, 0, 0, none);
        add_row(65535, 3, 511, 2, 0, none);
        add_row(65535, 3, 170, 1, 0, none);

        foreach (rows[i]) begin
            set_config(rows[i].radius, rows[i].detail);
            send_word(rows[i].tri_idx, rows[i].corner, rows[i].typed, rows[i].want);
        end

        plan_det = '{0, 1, 2, 3};
        plan_cnt = '{300, 90, 40, 30};
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 48 : 0;
            recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 36 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                rad = (mode == 0 && ph == 0) ? 16'd0 :
                      (mode == 1 && ph == 0) ? 16'hFFFF : 16'($urandom);
                set_config(rad, 2'(plan_det[ph]));
                lim = 8 << (2 * plan_det[ph]);
                for (int k = 0; k < plan_cnt[ph]; k++) begin
                    if (mode == 0 && ph == 0 && k == 20) hold_req = 1'b1;
                    // drain fully once in the middle of a run
                    if (mode == 1 && ph == 0 && k == 150) wait_drained();
                    if ($urandom_range(9) == 0) idx = 9'($urandom);
                    else idx = 9'($urandom_range(lim - 1));
                    send_word(idx, 2'($urandom), 0, none);
                end
            end
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && vertex_q.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/ost_pkg.sv
sv/ost_in_if.sv
sv/ost_out_if.sv
sv/octahedron_sphere_tessellator.sv
sim/octahedron_sphere_tessellator_test.sv
